@@ rtl/legendre_recurrence_defines.svh @@
// assertion macros shared by the legendre recurrence rtl
`ifndef LEGENDRE_RECURRENCE_DEFINES_SVH
`define LEGENDRE_RECURRENCE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lr_pkg.sv @@
// shared types, constants and reciprocal table for the legendre recurrence
package lr_pkg;

  localparam int PolyW    = 18;               // signed q1.16 value width
  localparam int OrdW     = 5;                // order field width
  localparam int RecipW   = 20;               // reciprocal fraction bits
  localparam int LoW      = 20;               // low slice of the numerator
  localparam int NumW     = 41;               // numerator width, q32
  localparam int MulW     = 21;               // shared multiplier operand width
  localparam int XpW      = 36;               // x * p1 product width
  localparam int T2W      = PolyW + OrdW + 1; // (l-1) * p2 width
  localparam int FracShift = RecipW + 16;     // q52 to q16

  localparam logic signed [PolyW-1:0] ONE_Q16 = 18'sd65536;
  localparam logic signed [63:0] RoundBias = 64'sd1 <<< (FracShift - 1);

  // round(2^20 / l), halves up; entries for orders zero and one are unused
  localparam logic [RecipW-1:0] RECIP_TABLE [2**OrdW] = '{
    20'd0,      20'd0,      20'd524288, 20'd349525,
    20'd262144, 20'd209715, 20'd174763, 20'd149797,
    20'd131072, 20'd116508, 20'd104858, 20'd95325,
    20'd87381,  20'd80660,  20'd74898,  20'd69905,
    20'd65536,  20'd61681,  20'd58254,  20'd55188,
    20'd52429,  20'd49932,  20'd47663,  20'd45590,
    20'd43691,  20'd41943,  20'd40330,  20'd38836,
    20'd37449,  20'd36158,  20'd34953,  20'd33825
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_XP,
    ST_NUM,
    ST_LO,
    ST_HI,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_ONE,
    OP_EMIT_X,
    OP_MUL_XP,
    OP_FORM_NUM,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_EMIT_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a value this cycle
    logic is_last;   // current order equals the order limit
  } status_t;

endpackage

@@ rtl/lr_ctrl.sv @@
// sequencing state machine for the legendre recurrence
`include "legendre_recurrence_defines.svh"

module lr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lr_pkg::status_t sts_i,
  output lr_pkg::cmd_t    cmd_o
);

  lr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lr_pkg::ST_P0;
      end
      lr_pkg::ST_P0: begin
        if (sts_i.out_free) state_d = sts_i.is_last ? lr_pkg::ST_IDLE : lr_pkg::ST_P1;
      end
      lr_pkg::ST_P1: begin
        if (sts_i.out_free) state_d = sts_i.is_last ? lr_pkg::ST_IDLE : lr_pkg::ST_XP;
      end
      lr_pkg::ST_XP:  state_d = lr_pkg::ST_NUM;
      lr_pkg::ST_NUM: state_d = lr_pkg::ST_LO;
      lr_pkg::ST_LO:  state_d = lr_pkg::ST_HI;
      lr_pkg::ST_HI:  state_d = lr_pkg::ST_FIN;
      lr_pkg::ST_FIN: begin
        if (sts_i.out_free) state_d = sts_i.is_last ? lr_pkg::ST_IDLE : lr_pkg::ST_XP;
      end
      default: state_d = lr_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.op = lr_pkg::OP_NONE;
    unique case (state_q)
      lr_pkg::ST_IDLE: if (in_valid_i) cmd_o.op = lr_pkg::OP_LOAD;
      lr_pkg::ST_P0:   if (sts_i.out_free) cmd_o.op = lr_pkg::OP_EMIT_ONE;
      lr_pkg::ST_P1:   if (sts_i.out_free) cmd_o.op = lr_pkg::OP_EMIT_X;
      lr_pkg::ST_XP:   cmd_o.op = lr_pkg::OP_MUL_XP;
      lr_pkg::ST_NUM:  cmd_o.op = lr_pkg::OP_FORM_NUM;
      lr_pkg::ST_LO:   cmd_o.op = lr_pkg::OP_MUL_LO;
      lr_pkg::ST_HI:   cmd_o.op = lr_pkg::OP_MUL_HI;
      lr_pkg::ST_FIN:  if (sts_i.out_free) cmd_o.op = lr_pkg::OP_EMIT_STEP;
      default:         cmd_o.op = lr_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = (state_q != lr_pkg::ST_IDLE);

  `LR_ASSERT_NEXT(a_accept_starts, state_q == lr_pkg::ST_IDLE && in_valid_i, state_q == lr_pkg::ST_P0, "accepted item did not start at order zero")
  `LR_ASSERT_NEXT(a_step_loops, state_q == lr_pkg::ST_FIN && sts_i.out_free && !sts_i.is_last, state_q == lr_pkg::ST_XP, "recurrence did not continue to the next order")
  `LR_ASSERT_NEXT(a_emit_waits, (state_q == lr_pkg::ST_P0 || state_q == lr_pkg::ST_P1 || state_q == lr_pkg::ST_FIN) && !sts_i.out_free, state_q == $past(state_q), "emit state left while output was blocked")

endmodule

@@ rtl/lr_datapath.sv @@
// recurrence datapath with shared multiplier and output register
`include "legendre_recurrence_defines.svh"

module lr_datapath #(
  parameter int unsigned MAX_ORDER = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lr_pkg::cmd_t                     cmd_i,
  output lr_pkg::status_t                  sts_o,
  input  logic signed [lr_pkg::PolyW-1:0]  x_value_i,
  input  logic [lr_pkg::OrdW-1:0]          order_max_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [lr_pkg::OrdW-1:0]          order_index_o,
  output logic signed [lr_pkg::PolyW-1:0]  poly_value_o,
  output logic                             last_value_o
);

  localparam int CapW = lr_pkg::OrdW + 1;
  localparam logic [CapW-1:0] OrdCap = CapW'(MAX_ORDER);
  localparam int NumFullW = lr_pkg::XpW + 7;

  // held request and recurrence state
  logic signed [lr_pkg::PolyW-1:0] x_q, x_d;
  logic [lr_pkg::OrdW-1:0]         n_q, n_d;
  logic [lr_pkg::OrdW-1:0]         l_q, l_d;
  logic signed [lr_pkg::PolyW-1:0] p1_q, p1_d, p2_q, p2_d;

  // step intermediates
  logic signed [lr_pkg::XpW-1:0]   xp_q, xp_d;
  logic signed [lr_pkg::T2W-1:0]   t2_q, t2_d;
  logic signed [lr_pkg::NumW-1:0]  num_q, num_d;
  logic [2*lr_pkg::LoW-1:0]        lo_q, lo_d;
  logic signed [2*lr_pkg::MulW-1:0] hi_q, hi_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [lr_pkg::OrdW-1:0]         order_q, order_d;
  logic signed [lr_pkg::PolyW-1:0] poly_q, poly_d;
  logic                            last_q, last_d;

  logic signed [lr_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [2*lr_pkg::MulW-1:0] mul_p;
  logic [lr_pkg::RecipW-1:0]        recip;
  logic signed [lr_pkg::PolyW-1:0]  x_clamp;
  logic [lr_pkg::OrdW-1:0]          n_clamp;
  logic [lr_pkg::OrdW-1:0]          lm1;
  logic [lr_pkg::OrdW:0]            coef;
  logic signed [NumFullW-1:0]       num_full;
  logic signed [63:0]               acc, rnd;
  logic signed [lr_pkg::PolyW-1:0]  step_val;
  logic                             out_free, is_last, emit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (l_q == n_q);
  assign sts_o.out_free = out_free;
  assign sts_o.is_last  = is_last;

  // input clamping
  always_comb begin
    if (x_value_i > lr_pkg::ONE_Q16) begin
      x_clamp = lr_pkg::ONE_Q16;
    end else if (x_value_i < -lr_pkg::ONE_Q16) begin
      x_clamp = -lr_pkg::ONE_Q16;
    end else begin
      x_clamp = x_value_i;
    end
    if ({1'b0, order_max_i} > OrdCap) begin
      n_clamp = OrdCap[lr_pkg::OrdW-1:0];
    end else begin
      n_clamp = order_max_i;
    end
  end

  assign recip = lr_pkg::RECIP_TABLE[l_q];
  assign lm1   = l_q - lr_pkg::OrdW'(1);
  assign coef  = {l_q, 1'b0} - CapW'(1);

  // shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      lr_pkg::OP_MUL_XP: begin
        mul_a = lr_pkg::MulW'(x_q);
        mul_b = lr_pkg::MulW'(p1_q);
      end
      lr_pkg::OP_MUL_LO: begin
        mul_a = $signed({1'b0, num_q[lr_pkg::LoW-1:0]});
        mul_b = $signed({1'b0, recip});
      end
      lr_pkg::OP_MUL_HI: begin
        mul_a = $signed(num_q[lr_pkg::NumW-1:lr_pkg::LoW]);
        mul_b = $signed({1'b0, recip});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // numerator in q32
  always_comb begin
    logic signed [NumFullW-1:0] xp_ext, coef_ext, t2_ext;
    xp_ext   = NumFullW'(xp_q);
    coef_ext = NumFullW'($signed({1'b0, coef}));
    t2_ext   = NumFullW'(t2_q);
    num_full = xp_ext * coef_ext - (t2_ext <<< 16);
  end

  // recombine, round half up, saturate
  always_comb begin
    acc = (64'(hi_q) <<< lr_pkg::LoW) + $signed({24'd0, lo_q}) + lr_pkg::RoundBias;
    rnd = acc >>> lr_pkg::FracShift;
    if (rnd > 64'(lr_pkg::ONE_Q16)) begin
      step_val = lr_pkg::ONE_Q16;
    end else if (rnd < -64'(lr_pkg::ONE_Q16)) begin
      step_val = -lr_pkg::ONE_Q16;
    end else begin
      step_val = rnd[lr_pkg::PolyW-1:0];
    end
  end

  always_comb begin
    x_d   = x_q;
    n_d   = n_q;
    l_d   = l_q;
    p1_d  = p1_q;
    p2_d  = p2_q;
    xp_d  = xp_q;
    t2_d  = t2_q;
    num_d = num_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    emit    = 1'b0;
    poly_d  = poly_q;
    unique case (cmd_i.op)
      lr_pkg::OP_LOAD: begin
        x_d = x_clamp;
        n_d = n_clamp;
        l_d = '0;
      end
      lr_pkg::OP_EMIT_ONE: begin
        emit   = 1'b1;
        poly_d = lr_pkg::ONE_Q16;
        p1_d   = lr_pkg::ONE_Q16;
        p2_d   = '0;
        l_d    = l_q + lr_pkg::OrdW'(1);
      end
      lr_pkg::OP_EMIT_X: begin
        emit   = 1'b1;
        poly_d = x_q;
        p1_d   = x_q;
        p2_d   = p1_q;
        l_d    = l_q + lr_pkg::OrdW'(1);
      end
      lr_pkg::OP_MUL_XP: begin
        xp_d = mul_p[lr_pkg::XpW-1:0];
        t2_d = $signed({1'b0, lm1}) * p2_q;
      end
      lr_pkg::OP_FORM_NUM: begin
        num_d = num_full[lr_pkg::NumW-1:0];
      end
      lr_pkg::OP_MUL_LO: begin
        lo_d = mul_p[2*lr_pkg::LoW-1:0];
      end
      lr_pkg::OP_MUL_HI: begin
        hi_d = mul_p;
      end
      lr_pkg::OP_EMIT_STEP: begin
        emit   = 1'b1;
        poly_d = step_val;
        p1_d   = step_val;
        p2_d   = p1_q;
        l_d    = l_q + lr_pkg::OrdW'(1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign order_d = emit ? l_q : order_q;
  assign last_d  = emit ? is_last : last_q;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      x_q         <= '0;
      n_q         <= '0;
      l_q         <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      n_q         <= n_d;
      l_q         <= l_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xp_q    <= xp_d;
    t2_q    <= t2_d;
    num_q   <= num_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    order_q <= order_d;
    poly_q  <= poly_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign order_index_o = order_q;
  assign poly_value_o  = poly_q;
  assign last_value_o  = last_q;

  `LR_ASSERT_SAME(a_out_range, out_valid_q, poly_q <= lr_pkg::ONE_Q16 && poly_q >= -lr_pkg::ONE_Q16, "output value outside plus or minus one")
  `LR_ASSERT_SAME(a_step_order, cmd_i.op == lr_pkg::OP_EMIT_STEP, l_q >= lr_pkg::OrdW'(2) && l_q <= n_q, "recurrence step at an order out of range")
  `LR_ASSERT_SAME(a_no_overwrite, emit, !out_valid_q || !out_stall_i, "output register overwritten while stalled")

endmodule

@@ rtl/legendre_recurrence.sv @@
// top level of the legendre polynomial generator (bonnet recurrence)
//
// input channel: in_valid_i / in_stall_o carry one item, an argument x_value_i
// (signed q1.16, clamped to plus or minus one) and a highest order order_max_i
// (limited to MAX_ORDER). output channel: out_valid_o / out_stall_i carry one
// item per order, order_index_o, poly_value_o (signed q1.16) and last_value_o,
// set on the value for the highest order. orders come out in increasing order.
// the value for order zero is registered from state P0 after the accept, order
// one from P1, every further order from FIN after the XP, NUM, LO and HI steps.
// an item is taken only once the last value of the one before is registered;
// each order n >= 2 spends five steps, three of them on the single shared 21x21
// multiplier (x*p, two reciprocal partial products).
// the input stalls from the accept until the last value has been registered.
// a stall on the output holds the waiting value and freezes the sequencer at
// its next emit step; an item can be accepted while the last value still waits.
// reset (rst_ni low, asynchronous) empties the output register and returns the
// sequencer to idle.
module legendre_recurrence #(
  parameter int unsigned MAX_ORDER = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [lr_pkg::PolyW-1:0]  x_value_i,
  input  logic [lr_pkg::OrdW-1:0]          order_max_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lr_pkg::OrdW-1:0]          order_index_o,
  output logic signed [lr_pkg::PolyW-1:0]  poly_value_o,
  output logic                             last_value_o
);

  // command and status between sequencer and datapath
  lr_pkg::cmd_t    cmd;
  lr_pkg::status_t sts;

  // sequencer: idle, one state per emit and per multiplier step, and the numerator step
  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: held request, last two values, shared multiplier, output register
  lr_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .x_value_i     (x_value_i),
    .order_max_i   (order_max_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .order_index_o (order_index_o),
    .poly_value_o  (poly_value_o),
    .last_value_o  (last_value_o)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for legendre_recurrence: directed and random requests
module tb_top;

  localparam int MaxOrder   = 16;
  localparam int HalfPeriod = 4;
  localparam int CycleLimit = 400000;
  localparam int Unit       = 65536;
  localparam int ShownMax   = 10;

  typedef logic signed [lr_pkg::PolyW-1:0] arg_t;
  typedef logic [lr_pkg::OrdW-1:0]         ord_t;

  typedef struct packed {
    logic [lr_pkg::OrdW-1:0]         order;
    logic signed [lr_pkg::PolyW-1:0] value;
    logic                            last;
  } poly_result_t;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic in_valid    = 1'b0;
  logic in_stall;
  arg_t x_value     = '0;
  ord_t order_max   = '0;
  logic out_valid;
  logic out_stall   = 1'b0;
  ord_t order_index;
  arg_t poly_value;
  logic last_value;

  poly_result_t poly_expect_q[$];
  poly_result_t want_value, got_value;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int cycle_count     = 0;
  int mismatch_count  = 0;
  int requests_sent   = 0;
  int values_checked  = 0;
  int clamped_args    = 0;
  int capped_orders   = 0;

  // predictor copy of the block state, holds the last request
  longint held_arg        = 0;
  int     held_limit      = 0;
  longint held_prev       = 0;
  longint held_prev_prev  = 0;

  legendre_recurrence #(
    .MAX_ORDER(MaxOrder)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .x_value_i    (x_value),
    .order_max_i  (order_max),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .order_index_o(order_index),
    .poly_value_o (poly_value),
    .last_value_o (last_value)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic longint clamp_unit(longint v);
    if (v > Unit) return Unit;
    if (v < -Unit) return -Unit;
    return v;
  endfunction

  // expected value sequence P0..Pn for one request
  function automatic void predict_values(arg_t x_raw, ord_t n_raw);
    longint x, p1, p2, v, num, recip;
    int n;
    x = clamp_unit(longint'(x_raw));
    n = (int'(n_raw) > MaxOrder) ? MaxOrder : int'(n_raw);
    if (x != longint'(x_raw)) clamped_args++;
    if (n != int'(n_raw)) capped_orders++;
    p2 = 0;
    p1 = Unit;
    poly_expect_q.push_back('{ord_t'(0), arg_t'(p1), n == 0});
    if (n >= 1) begin
      p2 = p1;
      p1 = x;
      poly_expect_q.push_back('{ord_t'(1), arg_t'(p1), n == 1});
    end
    for (int l = 2; l <= n; l++) begin
      num = longint'(2 * l - 1) * x * p1 - longint'(l - 1) * p2 * Unit;
      // divide by l through a rounded reciprocal, then round half up to q16
      recip = ((longint'(1) << lr_pkg::RecipW) + longint'(l >> 1)) / longint'(l);
      v = clamp_unit((num * recip + (longint'(1) << (lr_pkg::FracShift - 1)))
                     >>> lr_pkg::FracShift);
      p2 = p1;
      p1 = v;
      poly_expect_q.push_back('{ord_t'(l), arg_t'(v), l == n});
    end
    held_arg       = x;
    held_limit     = n;
    held_prev      = p1;
    held_prev_prev = p2;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_request(arg_t x, ord_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    x_value   <= x;
    order_max <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_values(x, n);
    requests_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_value = '{order_index, poly_value, last_value};
      values_checked++;
      if (poly_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ShownMax)
          $display("unexpected value: order %0d value %0d last %0d",
                   got_value.order, $signed(got_value.value), got_value.last);
      end else begin
        want_value = poly_expect_q.pop_front();
        if (want_value !== got_value) begin
          mismatch_count++;
          if (mismatch_count <= ShownMax)
            $display({"mismatch: expected order %0d value %0d last %0d,",
                      " got order %0d value %0d last %0d"},
                     want_value.order, $signed(want_value.value), want_value.last,
                     got_value.order, $signed(got_value.value), got_value.last);
        end
      end
    end
  end

  task automatic test_low_orders();
    send_request(arg_t'(0), ord_t'(0));
    send_request(arg_t'(Unit), ord_t'(1));
    send_request(arg_t'(-Unit), ord_t'(2));
    send_request(arg_t'(32768), ord_t'(3));
    send_request(arg_t'(-12345), ord_t'(0));
  endtask

  task automatic test_argument_extremes();
    send_request(arg_t'(Unit), ord_t'(MaxOrder));
    send_request(arg_t'(-Unit), ord_t'(MaxOrder));
    send_request(arg_t'(0), ord_t'(MaxOrder));
    send_request(arg_t'(1), ord_t'(5));
    send_request(arg_t'(-1), ord_t'(5));
    send_request(arg_t'(65535), ord_t'(9));
  endtask

  // arguments beyond plus or minus one get clamped first
  task automatic test_argument_clamping();
    send_request(arg_t'(131071), ord_t'(3));
    send_request(arg_t'(-131072), ord_t'(3));
    send_request(arg_t'(Unit + 1), ord_t'(4));
    send_request(arg_t'(-Unit - 1), ord_t'(4));
  endtask

  // orders above the limit act as the limit
  task automatic test_order_cap();
    send_request(arg_t'(40000), ord_t'(MaxOrder + 1));
    send_request(arg_t'(-20000), ord_t'(31));
    send_request(arg_t'(-50000), ord_t'(24));
  endtask

  task automatic test_random_requests(int count);
    arg_t x;
    ord_t n;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        x = arg_t'(int'($urandom_range(2 * Unit)) - Unit);
      end else if (pick < 88) begin
        x = arg_t'($urandom);  // whole field, about half out of range
      end else begin
        case ($urandom_range(4))
          0:       x = arg_t'(Unit);
          1:       x = arg_t'(-Unit);
          2:       x = arg_t'(0);
          3:       x = arg_t'(1);
          default: x = arg_t'(-1);
        endcase
      end
      if ($urandom_range(9) < 8) n = ord_t'($urandom_range(MaxOrder));
      else n = ord_t'($urandom_range(31));
      send_request(x, n);
    end
  endtask

  initial begin
    send_idle_pct  = 9;
    recv_stall_pct = 63;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_low_orders();
    test_argument_extremes();
    test_argument_clamping();
    test_order_cap();
    test_random_requests(150);
    send_idle_pct  = 63;
    recv_stall_pct = 9;
    test_random_requests(150);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_requests(142);
    in_valid <= 1'b0;
    while (poly_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    mismatch_count += poly_expect_q.size();
    $display("run: %0d requests, %0d values checked, %0d mismatches",
             requests_sent, values_checked, mismatch_count);
    $display("run: %0d clamped arguments, %0d orders capped, last order %0d at x %0d (%0d, %0d)",
             clamped_args, capped_orders, held_limit, held_arg, held_prev, held_prev_prev);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
